/* hdl/mau_pkg.sv */
// ---------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared types and fixed constants for the modular arithmetic unit.
// ---------------------------------------------------------------------------
package mau_pkg;

   localparam int OPERAND_WIDTH = 64;
   localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

   localparam logic [63:0] RESET_MODULUS = 64'd998244353;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_POW = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_A,
      ST_FIX_A,
      ST_RED_B,
      ST_FIX_B,
      ST_POW_CHK,
      ST_MUL,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MRET_RES,
      MRET_BASE,
      MRET_FINAL
   } mret_type;

endpackage

/* hdl/modular_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, multiply, Fermat-inverse divide and power modulo a
// configurable modulus, one transaction at a time.
// ---------------------------------------------------------------------------
// Each transaction runs through a single modular double-and-add unit, one bit
// per cycle. Both 64-bit operands are reduced bit-serially: the request is
// accepted, operand A is reduced and sign-fixed, then operand B, and the
// result is handed over once the output register is free. A multiply adds a
// bit-serial pass over the modulus bits. Power adds a final check plus, for
// each exponent bit up to the highest set one, a check and a squaring of the
// base, plus a multiply into the result where the bit is set; divide does the
// same over the bits of modulus-2 and ends with one more multiply. A modulus below two
// skips all of this. The request side stalls until the transaction has
// finished; the result sits in an output register, so a held result does not
// block the next request being accepted. The modulus register may only be
// written while no transaction is in flight.
// ---------------------------------------------------------------------------
module modular_arithmetic_unit #(
   parameter int MOD_WIDTH = 31,
   parameter int EXP_WIDTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [MOD_WIDTH-1:0]               csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_op,
   input  logic [mau_pkg::OPERAND_WIDTH-1:0]  req_operand_a,
   input  logic [mau_pkg::OPERAND_WIDTH-1:0]  req_operand_b,
   input  logic [mau_pkg::OPERAND_WIDTH-1:0]  req_exponent,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [MOD_WIDTH-1:0]               rsp_result,
   output logic                               rsp_operands_equal
);

   import mau_pkg::*;

   logic [MOD_WIDTH-1:0] modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_WIDTH'(RESET_MODULUS);
      end else if (csr_we) begin
         modulus_ff <= csr_wdata;
      end
   end

   mau_seq #(
      .MOD_WIDTH(MOD_WIDTH),
      .EXP_WIDTH(EXP_WIDTH)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .modulus           (modulus_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_operand_a     (req_operand_a),
      .req_operand_b     (req_operand_b),
      .req_exponent      (req_exponent),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result        (rsp_result),
      .rsp_operands_equal(rsp_operands_equal)
   );

endmodule

/* hdl/mau_modstep.sv */
// ---------------------------------------------------------------------------
// Modular double-and-add step
// Returns (2*acc + addend) mod m for acc, addend below m.
// ---------------------------------------------------------------------------
module mau_modstep #(
   parameter int MOD_WIDTH = 31
) (
   input  logic [MOD_WIDTH-1:0] acc,
   input  logic [MOD_WIDTH-1:0] addend,
   input  logic [MOD_WIDTH-1:0] modulus,
   output logic [MOD_WIDTH-1:0] step_out
);

   logic [MOD_WIDTH+1:0] sum;
   logic [MOD_WIDTH+1:0] m1;
   logic [MOD_WIDTH+1:0] m2;

   always_comb begin
      sum = {1'b0, acc, 1'b0} + {2'b00, addend};
      m1  = {2'b00, modulus};
      m2  = {1'b0, modulus, 1'b0};
      if (sum >= m2) begin
         step_out = MOD_WIDTH'(sum - m2);
      end else if (sum >= m1) begin
         step_out = MOD_WIDTH'(sum - m1);
      end else begin
         step_out = MOD_WIDTH'(sum);
      end
   end

endmodule

/* hdl/mau_seq.sv */
// ---------------------------------------------------------------------------
// Modular arithmetic sequencer
// Operand reduction and square-and-multiply, both driven through one shared
// modular step unit, plus the result register.
// ---------------------------------------------------------------------------
module mau_seq #(
   parameter int MOD_WIDTH = 31,
   parameter int EXP_WIDTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [MOD_WIDTH-1:0]               modulus,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_op,
   input  logic [mau_pkg::OPERAND_WIDTH-1:0]  req_operand_a,
   input  logic [mau_pkg::OPERAND_WIDTH-1:0]  req_operand_b,
   input  logic [mau_pkg::OPERAND_WIDTH-1:0]  req_exponent,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [MOD_WIDTH-1:0]               rsp_result,
   output logic                               rsp_operands_equal
);

   import mau_pkg::*;

   localparam int W    = MOD_WIDTH;
   localparam int OPW  = OPERAND_WIDTH;
   localparam int PE_W = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   mret_type             mret_ff, mret_in;
   logic [OPW-1:0]       mag_a_ff, mag_a_in;
   logic [OPW-1:0]       mag_b_ff, mag_b_in;
   logic                 neg_a_ff, neg_a_in;
   logic                 neg_b_ff, neg_b_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [W-1:0]         acc_ff, acc_in;
   logic [W-1:0]         a_ff, a_in;
   logic [W-1:0]         b_ff, b_in;
   logic [W-1:0]         mx_ff, mx_in;
   logic [W-1:0]         my_ff, my_in;
   logic [W-1:0]         base_ff, base_in;
   logic [W-1:0]         res_ff, res_in;
   logic [PE_W-1:0]      pexp_ff, pexp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]         rsp_result_ff, rsp_result_in;
   logic                 rsp_equal_ff, rsp_equal_in;

   logic [W-1:0]         step_addend;
   logic [W-1:0]         step_out;
   logic [W-1:0]         fix_val;
   logic [W:0]           add_sum;
   logic [W:0]           sub_diff;
   logic [W-1:0]         add_res;
   logic [W-1:0]         sub_res;
   logic [W-1:0]         fin_res;
   logic                 accept;
   logic                 trivial;

   mau_modstep #(
      .MOD_WIDTH(W)
   ) u_step (
      .acc     (acc_ff),
      .addend  (step_addend),
      .modulus (modulus),
      .step_out(step_out)
   );

   assign req_stall          = (state_ff != ST_IDLE);
   assign accept             = req_valid && !req_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_operands_equal = rsp_equal_ff;
   assign trivial            = (modulus <= W'(1));

   always_comb begin
      case (state_ff)
         ST_RED_A: step_addend = W'(mag_a_ff[OPW-1]);
         ST_RED_B: step_addend = W'(mag_b_ff[OPW-1]);
         default:  step_addend = my_ff[W-1] ? mx_ff : '0;
      endcase
   end

   // negative operands map to m - r unless the remainder is zero
   always_comb begin
      if (((state_ff == ST_FIX_A) ? neg_a_ff : neg_b_ff) && (acc_ff != '0)) begin
         fix_val = modulus - acc_ff;
      end else begin
         fix_val = acc_ff;
      end
   end

   always_comb begin
      add_sum  = {1'b0, a_ff} + {1'b0, b_ff};
      sub_diff = {1'b0, a_ff} - {1'b0, b_ff};
      add_res  = (add_sum >= {1'b0, modulus}) ? W'(add_sum - {1'b0, modulus})
                                              : W'(add_sum);
      sub_res  = sub_diff[W] ? W'(sub_diff + {1'b0, modulus}) : W'(sub_diff);
      if (trivial) begin
         fin_res = '0;
      end else begin
         unique case (op_ff) inside
            OP_ADD:                 fin_res = add_res;
            OP_SUB:                 fin_res = sub_res;
            OP_MUL, OP_DIV, OP_POW: fin_res = res_ff;
            default:                fin_res = '0;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      mret_in       = mret_ff;
      mag_a_in      = mag_a_ff;
      mag_b_in      = mag_b_ff;
      neg_a_in      = neg_a_ff;
      neg_b_in      = neg_b_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      base_in       = base_ff;
      res_in        = res_ff;
      pexp_in       = pexp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      rsp_equal_in  = rsp_equal_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_op);
               neg_a_in = req_operand_a[OPW-1];
               neg_b_in = req_operand_b[OPW-1];
               mag_a_in = req_operand_a[OPW-1] ? (~req_operand_a + OPW'(1)) : req_operand_a;
               mag_b_in = req_operand_b[OPW-1] ? (~req_operand_b + OPW'(1)) : req_operand_b;
               pexp_in  = PE_W'(req_exponent[EXP_WIDTH-1:0]);
               acc_in   = '0;
               cnt_in   = CNT_WIDTH'(OPW - 1);
               state_in = trivial ? ST_FINISH : ST_RED_A;
            end
         end
         ST_RED_A: begin
            acc_in   = step_out;
            mag_a_in = mag_a_ff << 1;
            cnt_in   = cnt_ff - CNT_WIDTH'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FIX_A;
            end
         end
         ST_FIX_A: begin
            a_in     = fix_val;
            acc_in   = '0;
            cnt_in   = CNT_WIDTH'(OPW - 1);
            state_in = ST_RED_B;
         end
         ST_RED_B: begin
            acc_in   = step_out;
            mag_b_in = mag_b_ff << 1;
            cnt_in   = cnt_ff - CNT_WIDTH'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FIX_B;
            end
         end
         ST_FIX_B: begin
            b_in   = fix_val;
            acc_in = '0;
            cnt_in = CNT_WIDTH'(W - 1);
            unique case (op_ff)
               OP_MUL: begin
                  mx_in    = a_ff;
                  my_in    = fix_val;
                  mret_in  = MRET_FINAL;
                  state_in = ST_MUL;
               end
               OP_DIV: begin
                  if (acc_ff == '0) begin
                     res_in   = '0;
                     state_in = ST_FINISH;
                  end else begin
                     base_in  = fix_val;
                     pexp_in  = PE_W'(modulus) - PE_W'(2);
                     res_in   = W'(1);
                     state_in = ST_POW_CHK;
                  end
               end
               OP_POW: begin
                  res_in = W'(1);
                  if (pexp_ff[EXP_WIDTH-1] || (pexp_ff == '0)) begin
                     state_in = ST_FINISH;
                  end else begin
                     base_in  = a_ff;
                     state_in = ST_POW_CHK;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_POW_CHK: begin
            acc_in = '0;
            cnt_in = CNT_WIDTH'(W - 1);
            if (pexp_ff == '0) begin
               if (op_ff == OP_DIV) begin
                  mx_in    = a_ff;
                  my_in    = res_ff;
                  mret_in  = MRET_FINAL;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (pexp_ff[0]) begin
               mx_in    = res_ff;
               my_in    = base_ff;
               mret_in  = MRET_RES;
               state_in = ST_MUL;
            end else begin
               mx_in    = base_ff;
               my_in    = base_ff;
               mret_in  = MRET_BASE;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in = step_out;
            my_in  = my_ff << 1;
            cnt_in = cnt_ff - CNT_WIDTH'(1);
            if (cnt_ff == '0) begin
               unique case (mret_ff)
                  MRET_RES: begin
                     res_in  = step_out;
                     mx_in   = base_ff;
                     my_in   = base_ff;
                     acc_in  = '0;
                     cnt_in  = CNT_WIDTH'(W - 1);
                     mret_in = MRET_BASE;
                  end
                  MRET_BASE: begin
                     base_in  = step_out;
                     pexp_in  = pexp_ff >> 1;
                     state_in = ST_POW_CHK;
                  end
                  default: begin
                     res_in   = step_out;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = fin_res;
               rsp_equal_in  = trivial || (a_ff == b_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      mret_ff       <= mret_in;
      mag_a_ff      <= mag_a_in;
      mag_b_ff      <= mag_b_in;
      neg_a_ff      <= neg_a_in;
      neg_b_ff      <= neg_b_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      mx_ff         <= mx_in;
      my_ff         <= my_in;
      base_ff       <= base_in;
      res_ff        <= res_in;
      pexp_ff       <= pexp_in;
      rsp_result_ff <= rsp_result_in;
      rsp_equal_ff  <= rsp_equal_in;
   end

endmodule
